FILE: hw/rtl/lbe_pkg.sv
// Shared types, constants and arithmetic helpers for the lattice band energy block.
// Used by lbe_cordic_cell, lbe_cos_lane and lattice_band_energy; depends on nothing.
package lbe_pkg;

    localparam int FRAC_BITS    = 24;
    localparam int CORDIC_STEPS = 30;
    // Range reduction register, rotation setup register, the cells, and the sign register.
    localparam int LANE_LAT     = CORDIC_STEPS + 3;

    localparam int ANG_W = 35;
    localparam int COS_W = 34;
    localparam int Z_W   = 33;
    localparam int ACC_W = 48;

    typedef logic signed [ANG_W-1:0] ang_t;
    typedef logic signed [COS_W-1:0] cos_t;
    typedef logic signed [Z_W-1:0]   z_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic signed [COS_W-1:0] x;
        logic signed [COS_W-1:0] y;
        logic signed [Z_W-1:0]   z;
        logic                    neg;
    } cordic_t;

    typedef enum logic [2:0] {
        MODEL_SQUARE     = 3'd0,
        MODEL_BILAYER    = 3'd1,
        MODEL_TRILAYER   = 3'd2,
        MODEL_QUADLAYER  = 3'd3,
        MODEL_TRIANGULAR = 3'd4
    } model_t;

    typedef enum logic [2:0] {
        REG_BAND_MODEL      = 3'd0,
        REG_MU_PRIMARY      = 3'd1,
        REG_MU_SECONDARY    = 3'd2,
        REG_ZEEMAN_FIELD    = 3'd3,
        REG_HOP_NEXT        = 3'd4,
        REG_HOP_THIRD       = 3'd5,
        REG_INTERLAYER_BASE = 3'd6,
        REG_INTERLAYER_KDEP = 3'd7
    } reg_idx_t;

    localparam cos_t                CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [32:0]  PI_Q30      = 33'sd3373259426;
    localparam logic signed [31:0]  INV2PI_Q32  = 32'sd683565276;
    localparam logic signed [31:0]  SQRT3_Q30   = 32'sd1859775393;
    localparam acc_t                SQRT2_Q28   = 48'sd379625062;
    localparam acc_t                GOLD_Q28    = 48'sd434337692;
    localparam acc_t                GOLDM1_Q28  = 48'sd165902236;

    localparam int SH_L = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
    localparam int SH_R = (FRAC_BITS >= 30) ? 0 : 30 - FRAC_BITS;

    function automatic z_t atan_q30(input int idx);
        z_t r;
        case (idx)
            0:  r = 33'sh03243F6A8;
            1:  r = 33'sh01DAC6705;
            2:  r = 33'sh00FADBAFC;
            3:  r = 33'sh007F56EA6;
            4:  r = 33'sh003FEAB76;
            5:  r = 33'sh001FFD55B;
            6:  r = 33'sh000FFFAAA;
            7:  r = 33'sh0007FFF55;
            8:  r = 33'sh0003FFFEA;
            9:  r = 33'sh0001FFFFD;
            10: r = 33'sh0000FFFFF;
            11: r = 33'sh00007FFFF;
            12: r = 33'sh00003FFFF;
            13: r = 33'sh00001FFFF;
            14: r = 33'sh00000FFFF;
            15: r = 33'sh000007FFF;
            16: r = 33'sh000003FFF;
            17: r = 33'sh000001FFF;
            18: r = 33'sh000000FFF;
            19: r = 33'sh0000007FF;
            20: r = 33'sh0000003FF;
            21: r = 33'sh0000001FF;
            22: r = 33'sh0000000FF;
            23: r = 33'sh00000007F;
            24: r = 33'sh00000003F;
            25: r = 33'sh00000001F;
            26: r = 33'sh00000000F;
            27: r = 33'sh000000008;
            28: r = 33'sh000000004;
            29: r = 33'sh000000002;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Signed product floored by sh bits.
    function automatic acc_t mul_asr(input acc_t a, input acc_t b, input int sh);
        logic signed [2*ACC_W-1:0] p;
        p = (2*ACC_W)'(a) * (2*ACC_W)'(b);
        return ACC_W'(p >>> sh);
    endfunction

    // Rescale a Q30 value to the energy fraction width, flooring.
    function automatic acc_t q30_to_frac(input acc_t v);
        return (v <<< SH_L) >>> SH_R;
    endfunction

endpackage

FILE: hw/rtl/lattice_band_energy.sv
// An accepted item passes the angle registers, cosine lanes, post-processing stages and
// output register. Throughput: one item per cycle while the output is not blocked; each
// of five cosine lanes is a 30-cell CORDIC chain taking a new angle each enabled cycle.
// A result waiting on the output does not stop the pipeline until it reaches the last
// stage. Reset (rst_n, asynchronous) clears the configuration registers and the pipeline
// valid bits to 0, which empties the pipeline; data registers are neither reset nor cleared.
// Depends on lbe_pkg and lbe_cos_lane.
module lattice_band_energy
    import lbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // kx [31:0], ky [63:32], species [67:64], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // energy [31:0]
    output logic [0:0]  m_tuser,   // species_error [0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    logic [2:0]         band_model_reg;
    logic signed [31:0] mu_primary_reg, mu_secondary_reg, zeeman_field_reg;
    logic signed [31:0] hop_next_reg, hop_third_reg;
    logic signed [31:0] interlayer_base_reg, interlayer_kdep_reg;

    logic               adv;
    logic               layered;
    logic signed [31:0] kx, ky;
    logic signed [63:0] r3prod;
    ang_t               a_next [5];
    ang_t               ang_reg [5];
    cos_t               cosv [5];

    logic [LANE_LAT:0]  side_v_reg;
    logic [3:0]         side_sp_reg [LANE_LAT+1];

    logic p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg;
    logic [3:0] p1_sp_reg, p2_sp_reg, p3_sp_reg, p4_sp_reg;
    acc_t p1_prod_a_reg, p1_prod_b_reg, p1_prod_c_reg, p1_dsq_reg;
    acc_t p1_csum_reg, p1_c2sum_reg, p1_c1_reg, p1_c3_reg;
    acc_t p2_tp_reg, p2_third_reg, p2_xk_reg, p2_lead_reg, p2_in1_reg, p2_in2_reg;
    acc_t p3_x_reg, p3_base_reg, p3_sq_reg, p3_tlead_reg, p3_thop_reg;
    acc_t p4_x_reg, p4_base_reg, p4_sq_reg, p4_tri_reg, p4_sx_reg, p4_gx_reg, p4_hx_reg;
    acc_t dcx;

    logic        out_valid_reg;
    logic [31:0] out_energy_reg;
    logic        out_err_reg;

    logic [3:0]  pair;
    logic        ok;
    acc_t        e_raw;
    acc_t        e_sat;

    localparam acc_t E_MAX = 48'sd2147483647;
    localparam acc_t E_MIN = -E_MAX - 48'sd1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_model_reg      <= '0;
            mu_primary_reg      <= '0;
            mu_secondary_reg    <= '0;
            zeeman_field_reg    <= '0;
            hop_next_reg        <= '0;
            hop_third_reg       <= '0;
            interlayer_base_reg <= '0;
            interlayer_kdep_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_BAND_MODEL:      band_model_reg      <= cfg_wdata[2:0];
                REG_MU_PRIMARY:      mu_primary_reg      <= cfg_wdata;
                REG_MU_SECONDARY:    mu_secondary_reg    <= cfg_wdata;
                REG_ZEEMAN_FIELD:    zeeman_field_reg    <= cfg_wdata;
                REG_HOP_NEXT:        hop_next_reg        <= cfg_wdata;
                REG_HOP_THIRD:       hop_third_reg       <= cfg_wdata;
                REG_INTERLAYER_BASE: interlayer_base_reg <= cfg_wdata;
                REG_INTERLAYER_KDEP: interlayer_kdep_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The pipeline moves unless a finished item would overwrite one still waiting.
    assign adv      = !p4_v_reg || !out_valid_reg || m_tready;
    assign s_tready = adv;

    // Lane angles: the layered models need kx, ky, 2kx, 2ky; the triangular one
    // needs sqrt3 kx / 2, ky, ky / 2, sqrt3 kx and 3 ky / 2.
    always_comb
    begin
        kx      = s_tdata[31:0];
        ky      = s_tdata[63:32];
        layered = (band_model_reg <= 3'(MODEL_QUADLAYER));
        r3prod  = 64'(kx) * 64'(SQRT3_Q30);
        a_next[0] = layered ? ANG_W'(kx) : ANG_W'(r3prod >>> 31);
        a_next[1] = ANG_W'(ky);
        a_next[2] = layered ? ANG_W'(kx) <<< 1 : ANG_W'(ky) >>> 1;
        a_next[3] = layered ? ANG_W'(ky) <<< 1 : ANG_W'(r3prod >>> 30);
        a_next[4] = (ANG_W'(ky) + (ANG_W'(ky) <<< 1)) >>> 1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 5; i++)
            begin
                ang_reg[i] <= a_next[i];
            end
            side_sp_reg[0] <= s_tdata[67:64];
            for (int i = 1; i <= LANE_LAT; i++)
            begin
                side_sp_reg[i] <= side_sp_reg[i-1];
            end
        end
    end

    for (genvar l = 0; l < 5; l++)
    begin : g_lane
        lbe_cos_lane u_lane
        (
            .clk     (clk),
            .en      (adv),
            .ang     (ang_reg[l]),
            .cos_out (cosv[l])
        );
    end

    assign dcx = ACC_W'(cosv[0]) - ACC_W'(cosv[1]);

    // Valid bits of the whole pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_v_reg <= '0;
            p1_v_reg   <= 1'b0;
            p2_v_reg   <= 1'b0;
            p3_v_reg   <= 1'b0;
            p4_v_reg   <= 1'b0;
        end
        else if (adv)
        begin
            side_v_reg <= {side_v_reg[LANE_LAT-1:0], s_tvalid};
            p1_v_reg   <= side_v_reg[LANE_LAT];
            p2_v_reg   <= p1_v_reg;
            p3_v_reg   <= p2_v_reg;
            p4_v_reg   <= p3_v_reg;
        end
    end

    // Post-processing of the cosines: products, then register terms, then the
    // constant-weighted interlayer terms.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_sp_reg     <= side_sp_reg[LANE_LAT];
            p1_prod_a_reg <= mul_asr(ACC_W'(cosv[0]), ACC_W'(cosv[1]), 30);
            p1_prod_b_reg <= mul_asr(ACC_W'(cosv[2]), ACC_W'(cosv[0]), 30);
            p1_prod_c_reg <= mul_asr(ACC_W'(cosv[0]), ACC_W'(cosv[4]), 30);
            p1_dsq_reg    <= mul_asr(dcx, dcx, 32);
            p1_csum_reg   <= ACC_W'(cosv[0]) + ACC_W'(cosv[1]);
            p1_c2sum_reg  <= ACC_W'(cosv[2]) + ACC_W'(cosv[3]);
            p1_c1_reg     <= ACC_W'(cosv[1]);
            p1_c3_reg     <= ACC_W'(cosv[3]);

            p2_sp_reg    <= p1_sp_reg;
            p2_tp_reg    <= mul_asr(ACC_W'(hop_next_reg), p1_prod_a_reg, 30) <<< 2;
            p2_third_reg <= mul_asr(ACC_W'(hop_third_reg), p1_c2sum_reg, 30) <<< 1;
            p2_xk_reg    <= mul_asr(ACC_W'(interlayer_kdep_reg), p1_dsq_reg, 28);
            p2_lead_reg  <= -(q30_to_frac(p1_csum_reg) <<< 1);
            p2_in1_reg   <= p1_c1_reg + (p1_prod_b_reg <<< 1);
            p2_in2_reg   <= p1_c3_reg + (p1_prod_c_reg <<< 1);

            p3_sp_reg    <= p2_sp_reg;
            p3_x_reg     <= ACC_W'(interlayer_base_reg) + p2_xk_reg;
            p3_base_reg  <= p2_lead_reg - p2_tp_reg - p2_third_reg;
            p3_sq_reg    <= p2_lead_reg - p2_tp_reg;
            p3_tlead_reg <= -(q30_to_frac(p2_in1_reg) <<< 1);
            p3_thop_reg  <= mul_asr(ACC_W'(hop_next_reg), p2_in2_reg, 30) <<< 1;

            p4_sp_reg   <= p3_sp_reg;
            p4_x_reg    <= p3_x_reg;
            p4_base_reg <= p3_base_reg;
            p4_sq_reg   <= p3_sq_reg;
            p4_tri_reg  <= p3_tlead_reg - ACC_W'(mu_primary_reg) - p3_thop_reg;
            p4_sx_reg   <= mul_asr(p3_x_reg, SQRT2_Q28, 28);
            p4_gx_reg   <= mul_asr(p3_x_reg, GOLD_Q28, 28);
            p4_hx_reg   <= mul_asr(p3_x_reg, GOLDM1_Q28, 28);
        end
    end

    // Band selection by model and species pair, then saturation.
    always_comb
    begin
        acc_t mu1;
        acc_t mu2;
        mu1   = ACC_W'(mu_primary_reg);
        mu2   = ACC_W'(mu_secondary_reg);
        pair  = 4'((5'(p4_sp_reg) + 5'd1) >> 1);
        ok    = 1'b0;
        e_raw = '0;
        case (model_t'(band_model_reg))
            MODEL_SQUARE:
            begin
                if (pair == 4'd1)
                begin
                    ok = 1'b1; e_raw = p4_sq_reg - mu1;
                end
            end
            MODEL_BILAYER:
            begin
                if (pair == 4'd1)
                begin
                    ok = 1'b1; e_raw = p4_base_reg - mu1 - p4_x_reg;
                end
                else if (pair == 4'd2)
                begin
                    ok = 1'b1; e_raw = p4_base_reg - mu2 + p4_x_reg;
                end
            end
            MODEL_TRILAYER:
            begin
                if (pair == 4'd1)
                begin
                    ok = 1'b1; e_raw = p4_base_reg - mu1 - p4_sx_reg;
                end
                else if (pair == 4'd2)
                begin
                    ok = 1'b1; e_raw = p4_base_reg - mu2;
                end
                else if (pair == 4'd3)
                begin
                    ok = 1'b1; e_raw = p4_base_reg - mu1 + p4_sx_reg;
                end
            end
            MODEL_QUADLAYER:
            begin
                if (pair == 4'd1)
                begin
                    ok = 1'b1; e_raw = p4_base_reg - mu1 - p4_gx_reg;
                end
                else if (pair == 4'd2)
                begin
                    ok = 1'b1; e_raw = p4_base_reg - mu2 - p4_hx_reg;
                end
                else if (pair == 4'd3)
                begin
                    ok = 1'b1; e_raw = p4_base_reg - mu1 + p4_hx_reg;
                end
                else if (pair == 4'd4)
                begin
                    ok = 1'b1; e_raw = p4_base_reg - mu1 + p4_gx_reg;
                end
            end
            MODEL_TRIANGULAR:
            begin
                if (p4_sp_reg == 4'd1)
                begin
                    ok = 1'b1; e_raw = p4_tri_reg - ACC_W'(zeeman_field_reg);
                end
                else if (p4_sp_reg == 4'd2)
                begin
                    ok = 1'b1; e_raw = p4_tri_reg + ACC_W'(zeeman_field_reg);
                end
            end
            default: ;
        endcase
        if (e_raw > E_MAX)
        begin
            e_sat = E_MAX;
        end
        else if (e_raw < E_MIN)
        begin
            e_sat = E_MIN;
        end
        else
        begin
            e_sat = e_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= p4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_energy_reg <= e_sat[31:0];
            out_err_reg    <= !ok;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_energy_reg;
    assign m_tuser[0] = out_err_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0))
        else $error("species error item carries a nonzero energy");

    a_bad_model: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && band_model_reg > 3'(MODEL_TRIANGULAR)) |-> m_tuser[0])
        else $error("unused model code produced a valid band");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && p4_v_reg) |-> !s_tready)
        else $error("input taken while the pipeline is blocked");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && p4_v_reg) |=> (p4_v_reg && $stable(p4_base_reg)))
        else $error("last pipeline stage moved during a stall");

endmodule

FILE: hw/rtl/lbe_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with its output register.
// Depends on lbe_pkg for the state struct and the arctangent table.
module lbe_cordic_cell
    import lbe_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic    clk,
    input  logic    en,
    input  cordic_t st_in,
    output cordic_t st_out
);

    cordic_t st_reg;
    cordic_t st_next;
    cos_t    xs;
    cos_t    ys;

    always_comb
    begin
        xs = $signed(st_in.x) >>> IDX;
        ys = $signed(st_in.y) >>> IDX;
        st_next.neg = st_in.neg;
        if ($signed(st_in.z) >= 0)
        begin
            st_next.x = $signed(st_in.x) - ys;
            st_next.y = $signed(st_in.y) + xs;
            st_next.z = $signed(st_in.z) - atan_q30(IDX);
        end
        else
        begin
            st_next.x = $signed(st_in.x) + ys;
            st_next.y = $signed(st_in.y) - xs;
            st_next.z = $signed(st_in.z) + atan_q30(IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

FILE: hw/rtl/lbe_cos_lane.sv
// Cosine lane: range reduction to a turn, fold to a half turn, then a chain of CORDIC cells.
// Depends on lbe_pkg and lbe_cordic_cell.
module lbe_cos_lane
    import lbe_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  ang_t ang,
    output cos_t cos_out
);

    logic signed [ANG_W+31:0] turn_prod;
    logic [31:0]              p_reg;
    logic [31:0]              wrap;
    logic                     fold;
    logic [31:0]              pf;
    logic signed [64:0]       zprod;
    cordic_t                  init_reg;
    cordic_t                  init_next;
    cordic_t                  chain [CORDIC_STEPS+1];
    cos_t                     cos_reg;

    // Angle times 1/(2 pi) gives the turn; p_reg takes the fraction of a turn from bits [59:28].
    assign turn_prod = (ANG_W+32)'(ang) * (ANG_W+32)'(INV2PI_Q32);

    always_comb
    begin
        wrap  = p_reg + 32'h4000_0000;
        fold  = wrap[31];
        pf    = fold ? (p_reg ^ 32'h8000_0000) : p_reg;
        zprod = 65'($signed(pf)) * 65'(PI_Q30);
        init_next.x   = CORDIC_GAIN;
        init_next.y   = '0;
        init_next.z   = Z_W'(zprod >>> 31);
        init_next.neg = fold;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= turn_prod[59:28];
            init_reg <= init_next;
            cos_reg  <= chain[CORDIC_STEPS].neg ? -$signed(chain[CORDIC_STEPS].x)
                                                : $signed(chain[CORDIC_STEPS].x);
        end
    end

    assign chain[0] = init_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        lbe_cordic_cell #(.IDX(i)) u_cell
        (
            .clk    (clk),
            .en     (en),
            .st_in  (chain[i]),
            .st_out (chain[i+1])
        );
    end

    assign cos_out = cos_reg;

endmodule
